FILE: hw/rtl/sha1_pkg.sv
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int WORD_WIDTH     = 32;
   localparam int COUNT_WIDTH    = 3;
   localparam int INDEX_WIDTH    = 3;
   localparam int BYTES_PER_WORD = 4;
   localparam int BLOCK_WORDS    = 16;
   localparam int BLOCK_BYTES    = 64;
   localparam int HASH_WORDS     = 5;
   localparam int ROUNDS         = 80;
   localparam int LENGTH_WIDTH   = 61;
   localparam int QUEUE_DEPTH    = 2;

   // byte position where the 64-bit bit length starts
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [HASH_WORDS-1:0][WORD_WIDTH-1:0] INIT_HASH = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [3:0][WORD_WIDTH-1:0] ROUND_CONST = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   typedef struct packed {
      logic [BLOCK_WORDS-1:0][WORD_WIDTH-1:0] words;
      logic                                   last_blk;
   } blk_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

endpackage

FILE: hw/rtl/sha1_channels.sv
`timescale 1ns / 1ps

interface sha1_req_if;
   logic                               valid;
   logic                               ready;
   logic [sha1_pkg::WORD_WIDTH-1:0]    message_word;
   logic [sha1_pkg::COUNT_WIDTH-1:0]   valid_bytes;
   logic                               end_of_message;

   modport source (output valid, output message_word, output valid_bytes,
                   output end_of_message, input ready);
   modport sink   (input valid, input message_word, input valid_bytes,
                   input end_of_message, output ready);
endinterface

interface sha1_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sha1_pkg::WORD_WIDTH-1:0]    digest_word;
   logic [sha1_pkg::INDEX_WIDTH-1:0]   word_index;
   logic                               last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

FILE: hw/rtl/sha1_front.sv
`timescale 1ns / 1ps

module sha1_front (
   input  logic                 clock,
   input  logic                 reset,
   sha1_req_if.sink             req_bus,
   input  sha1_pkg::q_stat_type q_stat,
   output logic                 push,
   output sha1_pkg::blk_type    push_blk
);

   localparam logic [1:0] ST_ACCEPT     = 2'd0;
   localparam logic [1:0] ST_PAD_FIRST  = 2'd1;
   localparam logic [1:0] ST_PAD_SECOND = 2'd2;

   logic [1:0]                            state_ff, state_in;
   logic [5:0]                            fill_ff, fill_in;
   logic [sha1_pkg::LENGTH_WIDTH-1:0]     len_ff, len_in;
   logic [sha1_pkg::BLOCK_WORDS-1:0][sha1_pkg::WORD_WIDTH-1:0] buf_ff, buf_in;

   logic [7:0] cur   [sha1_pkg::BLOCK_BYTES];
   logic [7:0] dat   [sha1_pkg::BLOCK_BYTES];
   logic [7:0] ovf   [sha1_pkg::BLOCK_BYTES];
   logic [7:0] pad   [sha1_pkg::BLOCK_BYTES];
   logic [7:0] padl  [sha1_pkg::BLOCK_BYTES];
   logic [7:0] zerol [sha1_pkg::BLOCK_BYTES];
   logic [sha1_pkg::COUNT_WIDTH-1:0] cnt;
   logic [6:0]                       sum;
   logic [63:0]                      bit_len;
   logic                             accept;

   function automatic logic [sha1_pkg::BLOCK_WORDS-1:0][sha1_pkg::WORD_WIDTH-1:0]
         pack_block(input logic [7:0] b [sha1_pkg::BLOCK_BYTES]);
      logic [sha1_pkg::BLOCK_WORDS-1:0][sha1_pkg::WORD_WIDTH-1:0] w;
      for (int k = 0; k < sha1_pkg::BLOCK_WORDS; k++) begin
         w[k] = {b[4*k], b[4*k+1], b[4*k+2], b[4*k+3]};
      end
      return w;
   endfunction

   assign req_bus.ready = (state_ff == ST_ACCEPT) && !q_stat.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign bit_len       = {len_ff, 3'b000};

   // byte view of the held block words
   always_comb begin
      for (int k = 0; k < sha1_pkg::BLOCK_BYTES; k++) begin
         cur[k] = buf_ff[k >> 2][sha1_pkg::WORD_WIDTH-1-8*(k & 3) -: 8];
      end
   end

   // saturate the byte count at one word
   assign cnt = (req_bus.valid_bytes > sha1_pkg::COUNT_WIDTH'(sha1_pkg::BYTES_PER_WORD))
              ? sha1_pkg::COUNT_WIDTH'(sha1_pkg::BYTES_PER_WORD) : req_bus.valid_bytes;
   assign sum = {1'b0, fill_ff} + 7'(cnt);

   // merge the word's bytes; bytes past the block end wrap into the next block
   always_comb begin
      logic [6:0] pos;
      pos = '0;
      dat = cur;
      for (int i = 0; i < sha1_pkg::BYTES_PER_WORD; i++) begin
         pos = {1'b0, fill_ff} + 7'(i);
         if (sha1_pkg::COUNT_WIDTH'(i) < cnt && !pos[6]) begin
            dat[pos[5:0]] = req_bus.message_word[sha1_pkg::WORD_WIDTH-1-8*i -: 8];
         end
      end
      ovf = dat;
      for (int i = 0; i < sha1_pkg::BYTES_PER_WORD; i++) begin
         pos = {1'b0, fill_ff} + 7'(i);
         if (sha1_pkg::COUNT_WIDTH'(i) < cnt && pos[6]) begin
            ovf[pos[5:0]] = req_bus.message_word[sha1_pkg::WORD_WIDTH-1-8*i -: 8];
         end
      end
   end

   // padded blocks: marker byte then zeros; the final one ends with the bit length in its last eight bytes
   always_comb begin
      for (int j = 0; j < sha1_pkg::BLOCK_BYTES; j++) begin
         if (6'(j) == fill_ff) begin
            pad[j] = sha1_pkg::PAD_BYTE;
         end else if (6'(j) > fill_ff) begin
            pad[j] = 8'h00;
         end else begin
            pad[j] = cur[j];
         end
         zerol[j] = 8'h00;
      end
      padl = pad;
      for (int m = 0; m < 8; m++) begin
         padl[int'(sha1_pkg::LEN_POS) + m]  = bit_len[63-8*m -: 8];
         zerol[int'(sha1_pkg::LEN_POS) + m] = bit_len[63-8*m -: 8];
      end
   end

   always_comb begin
      state_in          = state_ff;
      fill_in           = fill_ff;
      len_in            = len_ff;
      buf_in            = buf_ff;
      push              = 1'b0;
      push_blk.words    = pack_block(dat);
      push_blk.last_blk = 1'b0;
      case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               buf_in  = pack_block(ovf);
               push    = sum[6];
               fill_in = sum[5:0];
               len_in  = len_ff + sha1_pkg::LENGTH_WIDTH'(cnt);
               if (req_bus.end_of_message) begin
                  state_in = ST_PAD_FIRST;
               end
            end
         end
         ST_PAD_FIRST: begin
            if (!q_stat.full) begin
               push = 1'b1;
               if (fill_ff < sha1_pkg::LEN_POS) begin
                  push_blk.words    = pack_block(padl);
                  push_blk.last_blk = 1'b1;
                  fill_in           = '0;
                  len_in            = '0;
                  state_in          = ST_ACCEPT;
               end else begin
                  push_blk.words = pack_block(pad);
                  state_in       = ST_PAD_SECOND;
               end
            end
         end
         ST_PAD_SECOND: begin
            if (!q_stat.full) begin
               push              = 1'b1;
               push_blk.words    = pack_block(zerol);
               push_blk.last_blk = 1'b1;
               fill_in           = '0;
               len_in            = '0;
               state_in          = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         fill_ff  <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

FILE: hw/rtl/sha1_queue.sv
`timescale 1ns / 1ps

module sha1_queue #(
   parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sha1_pkg::blk_type    push_blk,
   input  logic                 pop,
   output sha1_pkg::q_stat_type q_stat,
   output sha1_pkg::blk_type    head
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   sha1_pkg::blk_type     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p);
      return (p == PTR_WIDTH'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_stat.full      = (cnt_ff == CNT_WIDTH'(DEPTH));
   assign q_stat.not_empty = (cnt_ff != '0);
   assign head             = mem_ff[rd_ptr_ff];
   assign do_push          = push && !q_stat.full;
   assign do_pop           = pop && q_stat.not_empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_blk;
      end
   end

endmodule

FILE: hw/rtl/sha1_back.sv
`timescale 1ns / 1ps

module sha1_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sha1_pkg::q_stat_type q_stat,
   input  sha1_pkg::blk_type    head,
   output logic                 pop,
   sha1_rsp_if.source           rsp_bus
);

   localparam logic [1:0] BK_IDLE   = 2'd0;
   localparam logic [1:0] BK_ROUND  = 2'd1;
   localparam logic [1:0] BK_FINISH = 2'd2;

   localparam logic [1:0] PHASE_CH     = 2'd0;
   localparam logic [1:0] PHASE_PARITY = 2'd1;
   localparam logic [1:0] PHASE_MAJ    = 2'd2;
   localparam logic [1:0] PHASE_TAIL   = 2'd3;

   localparam int RND_WIDTH = $clog2(sha1_pkg::ROUNDS);
   localparam logic [sha1_pkg::INDEX_WIDTH-1:0] LAST_INDEX =
      sha1_pkg::INDEX_WIDTH'(sha1_pkg::HASH_WORDS - 1);

   typedef logic [sha1_pkg::WORD_WIDTH-1:0] word_type;

   logic [1:0]                              state_ff, state_in;
   logic [RND_WIDTH-1:0]                    rnd_ff, rnd_in;
   logic                                    last_ff, last_in;
   word_type [sha1_pkg::BLOCK_WORDS-1:0]    sched_ff, sched_in;
   word_type [sha1_pkg::HASH_WORDS-1:0]     vars_ff, vars_in;
   word_type [sha1_pkg::HASH_WORDS-1:0]     hash_ff, hash_in;
   word_type [sha1_pkg::HASH_WORDS-1:0]     dig_ff, dig_in;
   word_type [sha1_pkg::HASH_WORDS-1:0]     folded;
   logic                                    busy_ff, busy_in;
   logic [sha1_pkg::INDEX_WIDTH-1:0]        idx_ff, idx_in;

   logic [1:0] phase;
   word_type   fn, temp, next_w, b, c, d;

   assign b = vars_ff[1];
   assign c = vars_ff[2];
   assign d = vars_ff[3];

   always_comb begin
      if (rnd_ff < RND_WIDTH'(20)) begin
         phase = PHASE_CH;
      end else if (rnd_ff < RND_WIDTH'(40)) begin
         phase = PHASE_PARITY;
      end else if (rnd_ff < RND_WIDTH'(60)) begin
         phase = PHASE_MAJ;
      end else begin
         phase = PHASE_TAIL;
      end
      case (phase)
         PHASE_CH:  fn = (b & c) | (~b & d);
         PHASE_MAJ: fn = (b & c) | (b & d) | (c & d);
         default:   fn = b ^ c ^ d;
      endcase
   end

   assign temp = {vars_ff[0][26:0], vars_ff[0][31:27]} + fn + vars_ff[4]
               + sched_ff[0] + sha1_pkg::ROUND_CONST[phase];
   assign next_w = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];

   always_comb begin
      for (int k = 0; k < sha1_pkg::HASH_WORDS; k++) begin
         folded[k] = hash_ff[k] + vars_ff[k];
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      last_in  = last_ff;
      sched_in = sched_ff;
      vars_in  = vars_ff;
      hash_in  = hash_ff;
      dig_in   = dig_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;

      // drain the digest one beat at a time
      if (busy_ff && rsp_bus.ready) begin
         if (idx_ff == LAST_INDEX) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      case (state_ff)
         BK_IDLE: begin
            if (q_stat.not_empty) begin
               pop      = 1'b1;
               sched_in = head.words;
               vars_in  = hash_ff;
               last_in  = head.last_blk;
               rnd_in   = '0;
               state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            for (int k = 0; k < sha1_pkg::BLOCK_WORDS - 1; k++) begin
               sched_in[k] = sched_ff[k+1];
            end
            sched_in[sha1_pkg::BLOCK_WORDS-1] = {next_w[30:0], next_w[31]};
            vars_in[0] = temp;
            vars_in[1] = vars_ff[0];
            vars_in[2] = {b[1:0], b[31:2]};
            vars_in[3] = c;
            vars_in[4] = d;
            rnd_in     = rnd_ff + 1'b1;
            if (rnd_ff == RND_WIDTH'(sha1_pkg::ROUNDS - 1)) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (!last_ff) begin
               hash_in  = folded;
               state_in = BK_IDLE;
            end else if (!busy_ff) begin
               // hand the digest to the output buffer and restart the chain
               dig_in   = folded;
               hash_in  = sha1_pkg::INIT_HASH;
               busy_in  = 1'b1;
               idx_in   = '0;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid       = busy_ff;
   assign rsp_bus.digest_word = dig_ff[idx_ff];
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == LAST_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         hash_ff  <= sha1_pkg::INIT_HASH;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         rnd_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         rnd_ff   <= rnd_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      vars_ff  <= vars_in;
      dig_ff   <= dig_in;
   end

endmodule

FILE: hw/rtl/sha1_message_digest_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// req_bus   in   message_word[31:0], valid_bytes[2:0], end_of_message
// rsp_bus   out  digest_word[31:0], word_index[2:0], last_word
//
// Words enter at one per cycle while the block queue has room and no padding block
// is pending; each full 64-byte block passes the round engine (load, rounds, fold)
// one at a time, and sustained throughput is set by the single shared round unit.
// A final word adds one or two padding blocks, then five digest beats follow.
// Reset is synchronous; no clearing pass.
// A stalled rsp_bus holds the digest; the engine keeps working on queued blocks
// and waits only when another digest is ready before the previous one has drained.

module sha1_message_digest_unit #(
   parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   sha1_req_if.sink    req_bus,
   sha1_rsp_if.source  rsp_bus
);

   sha1_pkg::q_stat_type q_stat;
   sha1_pkg::blk_type    push_blk;
   sha1_pkg::blk_type    head;
   logic                 push;
   logic                 pop;

   sha1_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_stat   (q_stat),
      .push     (push),
      .push_blk (push_blk)
   );

   sha1_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .q_stat   (q_stat),
      .head     (head)
   );

   sha1_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

FILE: hw/rtl/sha1_checker.sv
`timescale 1ns / 1ps

module sha1_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [sha1_pkg::WORD_WIDTH-1:0]    rsp_digest_word,
   input logic [sha1_pkg::INDEX_WIDTH-1:0]   rsp_word_index,
   input logic                               rsp_last_word
);

   localparam logic [sha1_pkg::INDEX_WIDTH-1:0] LAST_INDEX =
      sha1_pkg::INDEX_WIDTH'(sha1_pkg::HASH_WORDS - 1);

   // stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
                                 && $stable(rsp_word_index))
      else $error("digest beat changed while stalled");

   // digest beats run 0 to 4 back to back
   a_rsp_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 1'b1)
      else $error("digest beats out of sequence");

   a_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_word == (rsp_word_index == LAST_INDEX))
      else $error("last_word does not match word_index");

   a_rsp_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> rsp_word_index == '0)
      else $error("digest started at nonzero index");

endmodule

bind sha1_message_digest_unit sha1_checker u_sha1_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_digest_word (rsp_bus.digest_word),
   .rsp_word_index  (rsp_bus.word_index),
   .rsp_last_word   (rsp_bus.last_word)
);
